### rtl/isotp_pkg.sv
// ----------------------------------------------------------------------------
// ISO-TP receive package
// Shared transaction types, protocol codes and decode result structure.
// ----------------------------------------------------------------------------
`default_nettype none

package isotp_pkg;

  localparam int DATA_FIELDS = 8;
  localparam int FRAME_BYTES = 8;
  localparam int IDX_W       = $clog2(DATA_FIELDS);
  localparam int CNT_W       = $clog2(DATA_FIELDS + 1);
  localparam int LEN_W       = 12;
  localparam int SEQ_W       = 4;

  // protocol control nibble (upper half of the PCI byte)
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  // frame_kind codes
  localparam logic [2:0] KIND_SINGLE = 3'd0;
  localparam logic [2:0] KIND_FIRST  = 3'd1;
  localparam logic [2:0] KIND_CONSEC = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_SEQERR = 3'd4;

  typedef struct packed {
    logic [28:0] can_identifier;
    logic [3:0]  frame_length;
    logic [7:0]  data_byte_0;
    logic [7:0]  data_byte_1;
    logic [7:0]  data_byte_2;
    logic [7:0]  data_byte_3;
    logic [7:0]  data_byte_4;
    logic [7:0]  data_byte_5;
    logic [7:0]  data_byte_6;
    logic [7:0]  data_byte_7;
  } in_item_t;

  typedef struct packed {
    logic        is_payload;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_kind;
    logic [11:0] bytes_remaining;
    logic [7:0]  target_address;
    logic [28:0] source_identifier;
    logic        last_of_run;
  } out_item_t;

  // decode result handed from the decoder to the emitter and state registers
  typedef struct packed {
    logic [2:0]       kind;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] rem;
    logic [SEQ_W-1:0] seq_nxt;
    logic [LEN_W-1:0] rem_len_nxt;
  } dec_res_t;

endpackage

`default_nettype wire

### rtl/isotp_receive_reassembly_top.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembly
// Reassembles ISO-TP messages from received CAN frames, one frame at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one CAN frame per transaction (identifier, length, eight data
//           bytes). in_stall is high while a frame is being decoded or its
//           results are still being generated.
//   out_* : results of a frame, one per transaction: one per payload byte
//           (is_payload=1), then one status result with last_of_run=1.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : APB-style register port,
//           register 0 (byte address 0) holds extended_addressing in bit 0.
//           Write only while idle.
// Timing: a frame is captured, decoded in the next cycle, and the emitter then
//   produces one result per cycle while out_stall is low. The next frame is
//   taken only once the emitter has produced the status result of the last
//   one and the sequencer is back in idle; the single-byte walk through the
//   captured data in the emitter limits how soon that is. The last result
//   may still sit in the output register while the next frame is taken.
// Stall: when out_stall is high the output register holds its transaction
//   and the emitter waits; nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears the sequence counter, the
//   remaining length, the register and all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module isotp_receive_reassembly_top
  import isotp_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  // input frames
  input  wire             in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  // results
  output logic            out_valid,
  input  wire             out_stall,
  output out_item_t       out_data,
  // register port
  input  wire             psel,
  input  wire             penable,
  input  wire             pwrite,
  input  wire [2:0]       paddr,
  input  wire [31:0]      pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  in_item_t         frame_r;
  logic             ext_addr_r;
  logic [SEQ_W-1:0] exp_seq_r;
  logic [LEN_W-1:0] rem_len_r;
  dec_res_t         dec;
  logic             in_accept;
  logic             load;
  logic             emit_active;
  logic             reg_write;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign load      = (state_r == ST_DEC);

  // register port: one register, always ready
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? {31'b0, ext_addr_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_addr_r <= 1'b0;
    end else if (reg_write) begin
      ext_addr_r <= pwdata[0];
    end
  end

  // sequencer: capture, decode, then wait for the emitter to finish
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_DEC;
      end
      ST_DEC: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_active) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      exp_seq_r <= '0;
      rem_len_r <= '0;
    end else begin
      state_r <= state_nxt;
      // commit message state when the decode is handed to the emitter
      if (load) begin
        exp_seq_r <= dec.seq_nxt;
        rem_len_r <= dec.rem_len_nxt;
      end
    end
  end

  // hold the accepted frame through decode and emission
  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_r <= in_data;
    end
  end

  isotp_dec u_dec (
    .frame    (frame_r),
    .ext_addr (ext_addr_r),
    .exp_seq  (exp_seq_r),
    .rem_len  (rem_len_r),
    .res      (dec)
  );

  isotp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .frame     (frame_r),
    .dec       (dec),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .active    (emit_active)
  );

  a_accept_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_DEC))
    else $error("accepted frame not decoded");

  a_dec_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) |=> emit_active)
    else $error("emitter not started after decode");

  a_seqerr_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (load && dec.kind == KIND_SEQERR) |-> (dec.count == '0))
    else $error("sequence error carries payload");

  a_seq_reset_on_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load && dec.kind == KIND_FIRST) |=> (exp_seq_r == '0))
    else $error("first frame did not clear sequence");

endmodule

`default_nettype wire

### rtl/isotp_dec.sv
// ----------------------------------------------------------------------------
// ISO-TP frame decoder
// Decodes the PCI byte of one captured frame against the message state.
// ----------------------------------------------------------------------------
`default_nettype none

module isotp_dec
  import isotp_pkg::*;
(
  input  wire in_item_t         frame,
  input  wire                   ext_addr,
  input  wire [SEQ_W-1:0]       exp_seq,
  input  wire [LEN_W-1:0]       rem_len,
  output dec_res_t              res
);

  logic [CNT_W-1:0] present;
  logic [CNT_W-1:0] off1;
  logic [CNT_W-1:0] off2;
  logic [CNT_W-1:0] avail1;
  logic [CNT_W-1:0] avail2;
  logic [7:0]       pci;
  logic [7:0]       len_lo;
  logic [LEN_W-1:0] total;
  logic [SEQ_W-1:0] seq_inc;
  logic [CNT_W-1:0] cf_cnt;
  logic [LEN_W-1:0] cf_rem;

  always_comb begin
    present = (frame.frame_length > 4'(DATA_FIELDS)) ? CNT_W'(DATA_FIELDS)
                                                      : CNT_W'(frame.frame_length);
    pci     = ext_addr ? frame.data_byte_1 : frame.data_byte_0;
    len_lo  = ext_addr ? frame.data_byte_2 : frame.data_byte_1;
    off1    = CNT_W'(ext_addr) + CNT_W'(1);
    off2    = CNT_W'(ext_addr) + CNT_W'(2);
    avail1  = (present > off1) ? present - off1 : '0;
    avail2  = (present > off2) ? present - off2 : '0;
    total   = {pci[3:0], len_lo};
    seq_inc = exp_seq + SEQ_W'(1);
    cf_cnt  = (rem_len < LEN_W'(avail1)) ? CNT_W'(rem_len) : avail1;
    cf_rem  = rem_len - LEN_W'(cf_cnt);

    res             = '0;
    res.kind        = KIND_CONSEC;
    res.start       = off1[IDX_W-1:0];
    res.rem         = rem_len;
    res.seq_nxt     = exp_seq;
    res.rem_len_nxt = rem_len;

    unique case (pci[7:4])
      PCI_SINGLE: begin
        res.kind  = KIND_SINGLE;
        res.count = (CNT_W'(pci[3:0]) > avail1) ? avail1 : CNT_W'(pci[3:0]);
        res.rem   = '0;
      end
      PCI_FIRST: begin
        res.kind        = KIND_FIRST;
        res.count       = avail2;
        res.start       = off2[IDX_W-1:0];
        res.rem_len_nxt = (total > LEN_W'(avail2)) ? total - LEN_W'(avail2) : '0;
        res.rem         = res.rem_len_nxt;
        res.seq_nxt     = '0;
      end
      PCI_CONSEC: begin
        res.seq_nxt = seq_inc;
        if (pci[3:0] != seq_inc) begin
          res.kind = KIND_SEQERR;
        end else begin
          res.count       = cf_cnt;
          res.rem_len_nxt = cf_rem;
          res.rem         = cf_rem;
          res.kind        = (cf_rem == '0) ? KIND_END : KIND_CONSEC;
        end
      end
      default: begin
        res.kind = KIND_CONSEC;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/isotp_emit.sv
// ----------------------------------------------------------------------------
// ISO-TP result emitter
// Walks the captured data bytes one per cycle while the output is free, then closes with a status.
// ----------------------------------------------------------------------------
`default_nettype none

module isotp_emit
  import isotp_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            load,
  input  wire in_item_t  frame,
  input  wire dec_res_t  dec,
  input  wire            out_stall,
  output logic           out_valid,
  output out_item_t      out_data,
  output logic           active
);

  logic [7:0]       data_r [DATA_FIELDS];
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] left_r;
  logic [2:0]       kind_r;
  logic [LEN_W-1:0] rem_r;
  logic [28:0]      ident_r;
  logic             active_r;
  logic             out_valid_r;
  out_item_t        out_r;
  logic             slot_free;
  logic             fire;

  assign slot_free = !out_valid_r || !out_stall;
  assign fire      = active_r && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
      end else if (fire && left_r == '0) begin
        active_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      data_r[0] <= frame.data_byte_0;
      data_r[1] <= frame.data_byte_1;
      data_r[2] <= frame.data_byte_2;
      data_r[3] <= frame.data_byte_3;
      data_r[4] <= frame.data_byte_4;
      data_r[5] <= frame.data_byte_5;
      data_r[6] <= frame.data_byte_6;
      data_r[7] <= frame.data_byte_7;
      idx_r     <= dec.start;
      left_r    <= dec.count;
      kind_r    <= dec.kind;
      rem_r     <= dec.rem;
      ident_r   <= frame.can_identifier;
    end else if (fire && left_r != '0) begin
      idx_r  <= idx_r + IDX_W'(1);
      left_r <= left_r - CNT_W'(1);
    end
    if (fire) begin
      out_r.is_payload        <= (left_r != '0);
      out_r.payload_byte      <= (left_r != '0) ? data_r[idx_r] : 8'h00;
      out_r.frame_kind        <= kind_r;
      out_r.bytes_remaining   <= rem_r;
      out_r.target_address    <= data_r[0];
      out_r.source_identifier <= ident_r;
      out_r.last_of_run       <= (left_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign active    = active_r;

  a_last_xor_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.last_of_run != out_r.is_payload))
    else $error("status and payload flags disagree");

  a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (left_r <= CNT_W'(DATA_FIELDS)))
    else $error("byte count out of range");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !active_r)
    else $error("emitter loaded while busy");

endmodule

`default_nettype wire
